@@ hw/rtl/xmpnd_pkg.sv @@
// Package: shared types and constants of the packed note decoder.
`timescale 1ns / 1ps

package xmpnd_pkg;

   localparam logic [7:0] ABSENT_BYTE    = 8'hFF;
   localparam logic [7:0] KEY_OFF_NOTE   = 8'hFE;
   localparam logic [7:0] KEY_OFF_EFFECT = 8'd20;
   localparam logic [7:0] KEY_OFF_INDEX  = 8'd96;
   localparam logic [7:0] MAX_COMMAND    = 8'h0F;
   localparam logic [7:0] NO_INSTRUMENT  = 8'h00;

   // Fields of one completed note, before conversion.
   typedef struct packed {
      logic [7:0] note;
      logic [7:0] instrument;
      logic [7:0] volume;
      logic [7:0] effect;
      logic [7:0] param;
   } note_raw_type;

endpackage

@@ hw/rtl/xmpnd_if.sv @@
// Interfaces: byte request channel and note result channel.
`timescale 1ns / 1ps

interface xmpnd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface xmpnd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_note;
   logic [7:0] out_instrument;
   logic [7:0] out_volume;
   logic [3:0] out_command;
   logic [7:0] out_argument;

   modport source (output valid, output out_note, output out_instrument,
                   output out_volume, output out_command, output out_argument,
                   input ready);
   modport sink   (input valid, input out_note, input out_instrument,
                   input out_volume, input out_command, input out_argument,
                   output ready);
endinterface

@@ hw/rtl/xm_packed_note_decoder_top.sv @@
// Top level of the packed pattern note decoder.
//
//   channel   dir   modport   transfer moves
//   req_bus   in    sink      one packed pattern byte (in_byte)
//   rsp_bus   out   source    one converted note (note, instrument, volume, command, argument)
//
// One byte per cycle while rsp_bus is not stalled; a byte is decoded the cycle after its
// transfer unless a stall holds it, and its note, if it completes one, is on rsp_bus
// the cycle after that.
// Synchronous active-high reset clears the byte valid flag, the collection state
// and the result valid; held fields return to their defaults.
// A stalled result holds the decode stage; at most one more byte is taken into
// the input register before req_bus.ready drops.
`timescale 1ns / 1ps

module xm_packed_note_decoder_top (
   input  logic        clock,
   input  logic        reset,
   xmpnd_req_if.sink   req_bus,
   xmpnd_rsp_if.source rsp_bus
);

   logic                    take;
   logic                    raw_valid;
   xmpnd_pkg::note_raw_type raw;

   xmpnd_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .take      (take),
      .raw_valid (raw_valid),
      .raw       (raw)
   );

   xmpnd_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .raw_valid (raw_valid),
      .raw       (raw),
      .take      (take),
      .rsp_bus   (rsp_bus)
   );

endmodule

@@ hw/rtl/xmpnd_unpack.sv @@
// Unpack: input byte register and field collection state.
`timescale 1ns / 1ps

module xmpnd_unpack (
   input  logic                   clock,
   input  logic                   reset,
   xmpnd_req_if.sink              req_bus,
   input  logic                   take,
   output logic                   raw_valid,
   output xmpnd_pkg::note_raw_type raw
);

   localparam logic [2:0] PHASE_FIRST = 3'd0;
   localparam logic [2:0] PHASE_INS   = 3'd1;
   localparam logic [2:0] PHASE_VOL   = 3'd2;
   localparam logic [2:0] PHASE_EFF   = 3'd3;
   localparam logic [2:0] PHASE_PARAM = 3'd4;

   logic       byte_valid_ff, byte_valid_in;
   logic [7:0] byte_ff;
   logic       fire;

   logic [2:0] phase_ff, phase_in;
   logic [4:0] mask_ff, mask_in;
   logic       packed_ff, packed_in;
   logic [7:0] note_ff, note_in;
   logic [7:0] ins_ff, ins_in;
   logic [7:0] vol_ff, vol_in;
   logic [7:0] eff_ff, eff_in;
   logic       emit;
   logic [7:0] param;

   assign fire          = byte_valid_ff && take;
   assign req_bus.ready = !byte_valid_ff || take;

   always_comb begin
      if (req_bus.valid && req_bus.ready) begin
         byte_valid_in = 1'b1;
      end else if (fire) begin
         byte_valid_in = 1'b0;
      end else begin
         byte_valid_in = byte_valid_ff;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      mask_in   = mask_ff;
      packed_in = packed_ff;
      note_in   = note_ff;
      ins_in    = ins_ff;
      vol_in    = vol_ff;
      eff_in    = eff_ff;
      emit      = 1'b0;
      param     = xmpnd_pkg::ABSENT_BYTE;
      if (phase_ff == PHASE_FIRST) begin
         if (byte_ff[7]) begin
            packed_in = 1'b1;
            mask_in   = byte_ff[4:0];
            note_in   = xmpnd_pkg::ABSENT_BYTE;
            ins_in    = xmpnd_pkg::NO_INSTRUMENT;
            vol_in    = xmpnd_pkg::ABSENT_BYTE;
            eff_in    = xmpnd_pkg::ABSENT_BYTE;
            if (byte_ff[4:0] == 5'd0) begin
               emit = 1'b1;
            end else begin
               phase_in = PHASE_INS;
            end
         end else begin
            packed_in = 1'b0;
            mask_in   = 5'd0;
            note_in   = byte_ff;
            phase_in  = PHASE_INS;
         end
      end else if (packed_ff) begin
         // lowest pending mask bit selects the field this byte fills
         if (mask_ff[0]) begin
            note_in = byte_ff;
            mask_in = mask_ff & 5'b11110;
         end else if (mask_ff[1]) begin
            ins_in  = byte_ff;
            mask_in = mask_ff & 5'b11100;
         end else if (mask_ff[2]) begin
            vol_in  = byte_ff;
            mask_in = mask_ff & 5'b11000;
         end else if (mask_ff[3]) begin
            eff_in  = byte_ff;
            mask_in = mask_ff & 5'b10000;
         end else begin
            // parameter is always the last packed field
            param = byte_ff;
            emit  = 1'b1;
         end
         if (mask_in == 5'd0) begin
            emit = 1'b1;
         end
      end else begin
         case (phase_ff)
            PHASE_INS: begin
               ins_in   = byte_ff;
               phase_in = PHASE_VOL;
            end
            PHASE_VOL: begin
               vol_in   = byte_ff;
               phase_in = PHASE_EFF;
            end
            PHASE_EFF: begin
               eff_in   = byte_ff;
               phase_in = PHASE_PARAM;
            end
            default: begin
               param = byte_ff;
               emit  = 1'b1;
            end
         endcase
      end
      if (emit) begin
         phase_in = PHASE_FIRST;
         mask_in  = 5'd0;
      end
   end

   assign raw_valid      = fire && emit;
   assign raw.note       = note_in;
   assign raw.instrument = ins_in;
   assign raw.volume     = vol_in;
   assign raw.effect     = eff_in;
   assign raw.param      = param;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         phase_ff      <= PHASE_FIRST;
         mask_ff       <= 5'd0;
         packed_ff     <= 1'b0;
         note_ff       <= xmpnd_pkg::ABSENT_BYTE;
         ins_ff        <= xmpnd_pkg::NO_INSTRUMENT;
         vol_ff        <= xmpnd_pkg::ABSENT_BYTE;
         eff_ff        <= xmpnd_pkg::ABSENT_BYTE;
      end else begin
         byte_valid_ff <= byte_valid_in;
         if (fire) begin
            phase_ff  <= phase_in;
            mask_ff   <= mask_in;
            packed_ff <= packed_in;
            note_ff   <= note_in;
            ins_ff    <= ins_in;
            vol_ff    <= vol_in;
            eff_ff    <= eff_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         byte_ff <= req_bus.in_byte;
      end
   end

   a_emit_restarts: assert property (@(posedge clock) disable iff (reset)
      raw_valid |=> phase_ff == PHASE_FIRST && mask_ff == 5'd0)
      else $error("note completed but collection state not cleared");

   a_packed_pending: assert property (@(posedge clock) disable iff (reset)
      packed_ff && phase_ff != PHASE_FIRST |-> mask_ff != 5'd0)
      else $error("packed note in progress with empty mask");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_PARAM)
      else $error("field phase out of range");

endmodule

@@ hw/rtl/xmpnd_convert.sv @@
// Convert: note/effect conversion and result register.
`timescale 1ns / 1ps

module xmpnd_convert (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    raw_valid,
   input  xmpnd_pkg::note_raw_type raw,
   output logic                    take,
   xmpnd_rsp_if.source             rsp_bus
);

   logic       out_valid_ff, out_valid_in;
   logic [7:0] note_ff, note_in;
   logic [7:0] ins_ff, ins_in;
   logic [7:0] vol_ff;
   logic [3:0] cmd_ff, cmd_in;
   logic [7:0] arg_ff, arg_in;

   assign take = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      if (raw_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_comb begin
      ins_in = raw.instrument;
      cmd_in = 4'd0;
      arg_in = 8'd0;
      if (raw.note == 8'd0 || raw.note == xmpnd_pkg::ABSENT_BYTE) begin
         note_in = xmpnd_pkg::ABSENT_BYTE;
      end else begin
         note_in = raw.note - 8'd1;
      end
      if (note_in == xmpnd_pkg::KEY_OFF_INDEX) begin
         note_in = xmpnd_pkg::KEY_OFF_NOTE;
      end
      if (raw.effect <= xmpnd_pkg::MAX_COMMAND) begin
         cmd_in = raw.effect[3:0];
         arg_in = (raw.param == xmpnd_pkg::ABSENT_BYTE) ? 8'd0 : raw.param;
      end
      if (raw.effect == xmpnd_pkg::KEY_OFF_EFFECT) begin
         ins_in  = xmpnd_pkg::NO_INSTRUMENT;
         note_in = xmpnd_pkg::KEY_OFF_NOTE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (raw_valid) begin
         note_ff <= note_in;
         ins_ff  <= ins_in;
         vol_ff  <= raw.volume;
         cmd_ff  <= cmd_in;
         arg_ff  <= arg_in;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.out_note       = note_ff;
   assign rsp_bus.out_instrument = ins_ff;
   assign rsp_bus.out_volume     = vol_ff;
   assign rsp_bus.out_command    = cmd_ff;
   assign rsp_bus.out_argument   = arg_ff;

endmodule

@@ test/xm_packed_note_decoder_top_test.sv @@
// Self-checking testbench for the packed pattern note decoder: random byte streams, random stalls.
`timescale 1ns / 1ps

module xm_packed_note_decoder_top_test;

   localparam logic [7:0] MASK_FLAG = 8'h80;

   // collection phases of an unpacked note
   localparam logic [2:0] PH_FIRST      = 3'd0;
   localparam logic [2:0] PH_INSTRUMENT = 3'd1;
   localparam logic [2:0] PH_VOLUME     = 3'd2;
   localparam logic [2:0] PH_EFFECT     = 3'd3;

   // mask bits of a packed note
   localparam int FLD_NOTE       = 0;
   localparam int FLD_INSTRUMENT = 1;
   localparam int FLD_VOLUME     = 2;
   localparam int FLD_EFFECT     = 3;
   localparam int FLD_PARAM      = 4;

   localparam int STREAM_BYTES = 1600;

   typedef struct packed {
      logic [7:0] note;
      logic [7:0] instrument;
      logic [7:0] volume;
      logic [3:0] command;
      logic [7:0] argument;
   } note_cmd_type;

   typedef struct {
      logic [7:0] value;
      bit         wait_drain;
   } stim_byte_type;

   logic clock;
   logic reset;

   xmpnd_req_if req_bus ();
   xmpnd_rsp_if rsp_bus ();

   xm_packed_note_decoder_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   stim_byte_type byte_queue[$];
   note_cmd_type  notes_due[$];
   int         mismatches = 0;
   bit         req_fired = 0;
   int         gap_left = 0;
   int         burst_left = 1;
   int         rx_cycle = 0;
   int         rx_mode = 0;

   // decoder state as seen by the predictor
   logic [2:0] phase = PH_FIRST;
   logic [4:0] field_mask = '0;
   logic       packed_note = 1'b0;
   logic [7:0] held_note = xmpnd_pkg::ABSENT_BYTE;
   logic [7:0] held_instrument = xmpnd_pkg::NO_INSTRUMENT;
   logic [7:0] held_volume = xmpnd_pkg::ABSENT_BYTE;
   logic [7:0] held_effect = xmpnd_pkg::ABSENT_BYTE;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic note_cmd_type finish_note(logic [7:0] param);
      note_cmd_type r;
      logic [7:0]   n;
      n = (held_note == 8'h00 || held_note == xmpnd_pkg::ABSENT_BYTE) ?
          xmpnd_pkg::ABSENT_BYTE : held_note - 8'd1;
      if (n == xmpnd_pkg::KEY_OFF_INDEX)
         n = xmpnd_pkg::KEY_OFF_NOTE;
      r.instrument = held_instrument;
      r.command    = 4'd0;
      r.argument   = 8'h00;
      if (held_effect <= xmpnd_pkg::MAX_COMMAND) begin
         r.command  = held_effect[3:0];
         r.argument = (param == xmpnd_pkg::ABSENT_BYTE) ? 8'h00 : param;
      end
      if (held_effect == xmpnd_pkg::KEY_OFF_EFFECT) begin
         r.instrument = xmpnd_pkg::NO_INSTRUMENT;
         n = xmpnd_pkg::KEY_OFF_NOTE;
      end
      r.note     = n;
      r.volume   = held_volume;
      phase      = PH_FIRST;
      field_mask = '0;
      return r;
   endfunction

   function void decode_byte(logic [7:0] b);
      if (phase == PH_FIRST) begin
         if ((b & MASK_FLAG) != 8'h00) begin
            packed_note     = 1'b1;
            field_mask      = b[4:0];
            held_note       = xmpnd_pkg::ABSENT_BYTE;
            held_instrument = xmpnd_pkg::NO_INSTRUMENT;
            held_volume     = xmpnd_pkg::ABSENT_BYTE;
            held_effect     = xmpnd_pkg::ABSENT_BYTE;
            if (field_mask == '0)
               notes_due.push_back(finish_note(xmpnd_pkg::ABSENT_BYTE));
            else
               phase = PH_INSTRUMENT;
         end else begin
            packed_note = 1'b0;
            field_mask  = '0;
            held_note   = b;
            phase       = PH_INSTRUMENT;
         end
      end else if (packed_note) begin
         if (field_mask[FLD_NOTE]) begin
            held_note = b;
            field_mask[FLD_NOTE] = 1'b0;
         end else if (field_mask[FLD_INSTRUMENT]) begin
            held_instrument = b;
            field_mask[FLD_INSTRUMENT] = 1'b0;
         end else if (field_mask[FLD_VOLUME]) begin
            held_volume = b;
            field_mask[FLD_VOLUME] = 1'b0;
         end else if (field_mask[FLD_EFFECT]) begin
            held_effect = b;
            field_mask[FLD_EFFECT] = 1'b0;
         end else begin
            // parameter is always last and used straight away
            notes_due.push_back(finish_note(b));
            return;
         end
         if (field_mask == '0)
            notes_due.push_back(finish_note(xmpnd_pkg::ABSENT_BYTE));
      end else begin
         case (phase)
            PH_INSTRUMENT: begin
               held_instrument = b;
               phase = PH_VOLUME;
            end
            PH_VOLUME: begin
               held_volume = b;
               phase = PH_EFFECT;
            end
            PH_EFFECT: begin
               held_effect = b;
               phase = phase + 3'd1;
            end
            default: notes_due.push_back(finish_note(b));
         endcase
      end
   endfunction

   function void queue_byte(logic [7:0] v, bit drain);
      stim_byte_type s;
      s.value      = v;
      s.wait_drain = drain;
      byte_queue.push_back(s);
   endfunction

   function automatic logic [7:0] pick_data();
      logic [7:0] corner[10];
      corner = '{8'h00, 8'h01, 8'h60, 8'h61, 8'h7F, 8'h80, 8'hFE, 8'hFF, 8'h0F, 8'h10};
      if ($urandom_range(0, 9) < 3)
         return corner[$urandom_range(0, 9)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_effect();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10)
         return 8'($urandom_range(0, 15));
      if (r < 13)
         return xmpnd_pkg::KEY_OFF_EFFECT;
      return pick_data();
   endfunction

   function automatic logic [7:0] pick_note();
      if ($urandom_range(0, 3) == 0)
         return ($urandom_range(0, 1) == 1) ? 8'h61 : 8'h00;
      return 8'($urandom_range(0, 127));
   endfunction

   // one well-formed note with random content, first byte optionally waits for drain
   function void queue_note(bit drain);
      logic [7:0] mask;
      if ($urandom_range(0, 9) < 6) begin
         mask = MASK_FLAG | 8'($urandom_range(0, 127));
         if ($urandom_range(0, 15) == 0)
            mask[4:0] = '0;
         queue_byte(mask, drain);
         if (mask[FLD_NOTE])       queue_byte(pick_note(), 0);
         if (mask[FLD_INSTRUMENT]) queue_byte(pick_data(), 0);
         if (mask[FLD_VOLUME])     queue_byte(pick_data(), 0);
         if (mask[FLD_EFFECT])     queue_byte(pick_effect(), 0);
         if (mask[FLD_PARAM])      queue_byte(pick_data(), 0);
      end else begin
         queue_byte(pick_note(), drain);
         queue_byte(pick_data(), 0);
         queue_byte(pick_data(), 0);
         queue_byte(pick_effect(), 0);
         queue_byte(pick_data(), 0);
      end
   endfunction

   // sender: bursts of random length, random gaps between them
   always @(negedge clock) begin : drive
      stim_byte_type s;
      logic          nv;
      logic [7:0]    nb;
      nv = req_bus.valid;
      nb = req_bus.in_byte;
      if (reset) begin
         nv = 1'b0;
      end else if (!req_bus.valid || req_fired) begin
         nv = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (byte_queue.size() > 0 &&
                      !(byte_queue[0].wait_drain && notes_due.size() > 0)) begin
            s  = byte_queue.pop_front();
            nv = 1'b1;
            nb = s.value;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
      end
      req_bus.valid   <= nv;
      req_bus.in_byte <= nb;
   end

   // receiver: stall pattern switches among four randomly chosen modes
   always @(negedge clock) begin : accept
      logic nr;
      rx_cycle++;
      if (rx_cycle % 150 == 0)
         rx_mode = $urandom_range(0, 3);
      case (rx_mode)
         0:       nr = 1'b1;
         1:       nr = 1'($urandom_range(0, 1));
         2:       nr = (rx_cycle % 7) >= 3;
         default: nr = ($urandom_range(0, 3) == 0);
      endcase
      rsp_bus.ready <= nr;
   end

   always @(posedge clock) begin : watch
      note_cmd_type got;
      note_cmd_type want;
      req_fired = !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.out_note, rsp_bus.out_instrument, rsp_bus.out_volume,
                    rsp_bus.out_command, rsp_bus.out_argument};
            if (notes_due.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t unexpected note: note=%h ins=%h vol=%h cmd=%h arg=%h",
                           $realtime, got.note, got.instrument, got.volume,
                           got.command, got.argument);
               mismatches++;
            end else begin
               want = notes_due.pop_front();
               if (got !== want) begin
                  if (mismatches < 10)
                     $display("%0t note mismatch: exp %h/%h/%h/%h/%h got %h/%h/%h/%h/%h",
                              $realtime, want.note, want.instrument, want.volume,
                              want.command, want.argument, got.note, got.instrument,
                              got.volume, got.command, got.argument);
                  mismatches++;
               end
            end
         end
         if (req_fired)
            decode_byte(req_bus.in_byte);
      end
   end

   initial begin : stimulus
      logic [7:0] directed[24];
      bit         drained;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.in_byte = 8'h00;
      rsp_bus.ready   = 1'b0;

      directed = '{
         8'h80,                                   // empty mask
         8'hE0,                                   // empty mask, upper mask bits set
         8'h00, 8'hFF, 8'h00, 8'h0F, 8'hFF,       // unpacked, note zero, top command
         8'h61, 8'h05, 8'h40, 8'h14, 8'h12,       // key off note and key off effect
         8'h9F, 8'hFF, 8'h80, 8'hFF, 8'h10, 8'hAB, // all fields, mask byte as data
         8'h90, 8'h55,                            // parameter only
         8'h88, 8'h0A,                            // effect only
         8'h81, 8'h01                             // note only, lowest note
      };
      foreach (directed[i])
         queue_byte(directed[i], 0);

      drained = 0;
      while (byte_queue.size() < STREAM_BYTES) begin
         if ($urandom_range(0, 19) < 3) begin
            queue_byte(8'($urandom_range(0, 255)), 0);
         end else if (!drained && byte_queue.size() > STREAM_BYTES / 2) begin
            queue_note(1);
            drained = 1;
         end else begin
            queue_note(0);
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_queue.size() != 0 || req_bus.valid || notes_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatches == 0 && notes_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
